// ----- rtl/wpd_pkg.sv -----
// ----------------------------------------------------------------------------
// wpd_pkg
// Shared types and constants for the WAV PCM16 stream to DAC block.
// ----------------------------------------------------------------------------
package wpd_pkg;

    localparam int unsigned DATA_W   = 8;
    localparam int unsigned WORD_W   = 32;
    localparam int unsigned DAC_W    = 10;
    localparam int unsigned IDX_W    = 6;

    localparam logic [WORD_W-1:0] PCLK_RESET   = 32'd25000000;
    localparam logic [WORD_W-1:0] TAG_RIFF     = 32'h52494646;
    localparam logic [WORD_W-1:0] TAG_WAVE     = 32'h57415645;
    localparam logic [DATA_W-1:0] FMT_SIZE_PCM = 8'd16;
    localparam logic [DATA_W-1:0] SAMPLE_BITS  = 8'd16;
    localparam logic [DATA_W-1:0] CHAN_MONO    = 8'd1;
    localparam logic [DATA_W-1:0] CHAN_STEREO  = 8'd2;
    localparam logic [IDX_W-1:0]  HDR_LAST_IDX = 6'd43;
    localparam logic [DAC_W-1:0]  DAC_MID      = 10'd512;

    localparam logic [1:0] KIND_ACCEPT = 2'd0;
    localparam logic [1:0] KIND_REJECT = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] data_byte;
        logic              file_start;
    } t_in;

    typedef struct packed {
        logic [1:0]        kind;
        logic              channel;
        logic [DAC_W-1:0]  dac_code;
        logic [WORD_W-1:0] timer_period;
        logic [DATA_W-1:0] channel_count;
        logic              last_sample;
    } t_out;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEADER,
        ST_DIV,
        ST_DATA,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic hdr_byte;
        logic data_byte;
        logic div_start;
        logic load_reject;
        logic load_accept;
        logic load_sample;
    } t_cmd;

    typedef struct packed {
        logic hdr_last;
        logic hdr_ok;
        logic left_zero;
        logic odd;
        logic empty;
        logic div_done;
    } t_status;

endpackage

// ----- rtl/wpd_div.sv -----
// ----------------------------------------------------------------------------
// wpd_div
// Restoring divider, one quotient bit per cycle. Zero divisor saturates.
// ----------------------------------------------------------------------------
module wpd_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [wpd_pkg::WORD_W-1:0] i_dividend,
    input  logic [wpd_pkg::WORD_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [wpd_pkg::WORD_W-1:0] o_quot
);
    import wpd_pkg::*;

    localparam int unsigned CNT_W = $clog2(WORD_W + 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [WORD_W-1:0] r_rem, n_rem;
    logic [WORD_W-1:0] r_quot, n_quot;
    logic [WORD_W-1:0] r_dvs, n_dvs;
    logic [WORD_W:0]   w_rem_sh;
    logic [WORD_W:0]   w_diff;

    assign w_rem_sh = {r_rem, r_quot[WORD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    always_comb begin
        n_busy = r_busy;
        n_done = r_done;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quot = r_quot;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_dvs = i_divisor;
            n_rem = '0;
            n_cnt = '0;
            if (i_divisor == '0) begin
                n_quot = '1;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else begin
                n_quot = i_dividend;
                n_done = 1'b0;
                n_busy = 1'b1;
            end
        end else if (r_busy) begin
            // dividend shifts out of the top of quot as quotient bits shift in
            if (!w_diff[WORD_W]) begin
                n_rem  = w_diff[WORD_W-1:0];
                n_quot = {r_quot[WORD_W-2:0], 1'b1};
            end else begin
                n_rem  = w_rem_sh[WORD_W-1:0];
                n_quot = {r_quot[WORD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(WORD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem  <= n_rem;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ----- rtl/wpd_dp.sv -----
// ----------------------------------------------------------------------------
// wpd_dp
// Datapath: header capture and checks, sample assembly, period divider,
// clock frequency register and the result register.
// ----------------------------------------------------------------------------
module wpd_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wpd_pkg::WORD_W-1:0] i_cfg_wdata,
    input  wpd_pkg::t_in               i_in,
    input  wpd_pkg::t_cmd              i_cmd,
    output wpd_pkg::t_status           o_status,
    output wpd_pkg::t_out              o_out
);
    import wpd_pkg::*;

    logic [WORD_W-1:0] r_pclk;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [WORD_W-1:0] r_riff, n_riff;
    logic [WORD_W-1:0] r_form, n_form;
    logic [DATA_W-1:0] r_fmt, n_fmt;
    logic [DATA_W-1:0] r_chan, n_chan;
    logic [WORD_W-1:0] r_rate, n_rate;
    logic [DATA_W-1:0] r_bits, n_bits;
    logic [WORD_W-1:0] r_left, n_left;
    logic [DATA_W-1:0] r_pend, n_pend;
    logic              r_odd, n_odd;
    logic              r_right, n_right;
    t_out              r_out, n_out;

    logic [IDX_W-1:0]  w_idx;
    logic [4:0]        w_lane;
    logic [15:0]       w_raw;
    logic              w_div_done;
    logic [WORD_W-1:0] w_quot;

    // a start byte is always header byte zero
    assign w_idx  = i_in.file_start ? '0 : r_idx;
    assign w_lane = {w_idx[1:0], 3'b000};
    assign w_raw  = r_odd ? {i_in.data_byte, r_pend} : {8'h00, i_in.data_byte};

    wpd_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_pclk),
        .i_divisor  ({1'b0, r_rate[WORD_W-1:1]}),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_comb begin
        o_status.hdr_last  = (w_idx == HDR_LAST_IDX);
        o_status.hdr_ok    = (r_riff == TAG_RIFF) && (r_form == TAG_WAVE) &&
                             (r_fmt == FMT_SIZE_PCM) && (r_bits == SAMPLE_BITS) &&
                             ((r_chan == CHAN_MONO) || (r_chan == CHAN_STEREO));
        o_status.left_zero = (r_left == WORD_W'(1));
        o_status.odd       = r_odd;
        o_status.empty     = (r_left == '0);
        o_status.div_done  = w_div_done;
    end

    always_comb begin
        n_idx   = r_idx;
        n_riff  = r_riff;
        n_form  = r_form;
        n_fmt   = r_fmt;
        n_chan  = r_chan;
        n_rate  = r_rate;
        n_bits  = r_bits;
        n_left  = r_left;
        n_pend  = r_pend;
        n_odd   = r_odd;
        n_right = r_right;
        n_out   = r_out;

        if (i_cmd.hdr_byte) begin
            if (i_in.file_start) begin
                n_odd   = 1'b0;
                n_right = 1'b0;
            end
            case (w_idx) inside
                [6'd0:6'd3]:   n_riff = {r_riff[WORD_W-9:0], i_in.data_byte};
                [6'd8:6'd11]:  n_form = {r_form[WORD_W-9:0], i_in.data_byte};
                6'd16:         n_fmt  = i_in.data_byte;
                6'd22:         n_chan = i_in.data_byte;
                [6'd28:6'd31]: n_rate[w_lane +: 8] = i_in.data_byte;
                6'd34:         n_bits = i_in.data_byte;
                [6'd40:6'd43]: n_left[w_lane +: 8] = i_in.data_byte;
                default: ;
            endcase
            n_idx = o_status.hdr_last ? '0 : w_idx + 1'b1;
        end

        if (i_cmd.data_byte) begin
            n_left = r_left - 1'b1;
            if (!r_odd && !o_status.left_zero) begin
                n_pend = i_in.data_byte;
                n_odd  = 1'b1;
            end
        end

        if (i_cmd.load_sample) begin
            n_odd   = 1'b0;
            n_right = (r_chan == CHAN_STEREO) ? ~r_right : 1'b0;
            n_out.kind          = KIND_SAMPLE;
            n_out.channel       = r_right;
            n_out.dac_code      = {~w_raw[15], w_raw[14:6]};
            n_out.timer_period  = '0;
            n_out.channel_count = r_chan;
            n_out.last_sample   = o_status.left_zero;
        end

        if (i_cmd.load_reject) begin
            n_out.kind          = KIND_REJECT;
            n_out.channel       = 1'b0;
            n_out.dac_code      = '0;
            n_out.timer_period  = '0;
            n_out.channel_count = r_chan;
            n_out.last_sample   = 1'b0;
        end

        if (i_cmd.load_accept) begin
            n_odd   = 1'b0;
            n_right = 1'b0;
            n_out.kind          = KIND_ACCEPT;
            n_out.channel       = 1'b0;
            n_out.dac_code      = DAC_MID;
            n_out.timer_period  = w_quot;
            n_out.channel_count = r_chan;
            n_out.last_sample   = o_status.empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pclk  <= PCLK_RESET;
            r_idx   <= '0;
            r_odd   <= 1'b0;
            r_right <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_pclk <= i_cfg_wdata;
            end
            r_idx   <= n_idx;
            r_odd   <= n_odd;
            r_right <= n_right;
        end
        r_riff <= n_riff;
        r_form <= n_form;
        r_fmt  <= n_fmt;
        r_chan <= n_chan;
        r_rate <= n_rate;
        r_bits <= n_bits;
        r_left <= n_left;
        r_pend <= n_pend;
        r_out  <= n_out;
    end

    assign o_out = r_out;

endmodule

// ----- rtl/wpd_ctrl.sv -----
// ----------------------------------------------------------------------------
// wpd_ctrl
// Parser controller: file phase, divider wait and result valid flag.
// ----------------------------------------------------------------------------
module wpd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_file_start,
    input  logic             i_out_ready,
    input  wpd_pkg::t_status i_status,
    output wpd_pkg::t_cmd    o_cmd,
    output logic             o_in_ready,
    output logic             o_out_valid
);
    import wpd_pkg::*;

    t_state r_state, n_state;
    t_state w_eff;
    logic   r_out_valid, n_out_valid;
    logic   w_out_free;
    logic   w_accept;

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_eff      = i_file_start ? ST_HEADER : r_state;
    assign w_accept   = i_in_valid && o_in_ready;

    // outputs
    always_comb begin
        o_in_ready = (r_state != ST_DIV) && w_out_free;
        o_cmd      = '0;
        if (r_state == ST_DIV) begin
            o_cmd.load_accept = i_status.div_done && w_out_free;
        end else if (w_accept) begin
            case (w_eff)
                ST_HEADER: begin
                    o_cmd.hdr_byte = 1'b1;
                    if (i_status.hdr_last) begin
                        o_cmd.div_start   = i_status.hdr_ok;
                        o_cmd.load_reject = !i_status.hdr_ok;
                    end
                end
                ST_DATA: begin
                    o_cmd.data_byte   = 1'b1;
                    o_cmd.load_sample = i_status.odd || i_status.left_zero;
                end
                default: ;
            endcase
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_DIV: begin
                if (o_cmd.load_accept) begin
                    n_state = i_status.empty ? ST_DONE : ST_DATA;
                end
            end
            default: begin
                if (w_accept) begin
                    n_state = w_eff;
                    if (o_cmd.div_start) begin
                        n_state = ST_DIV;
                    end else if (o_cmd.load_reject) begin
                        n_state = ST_DONE;
                    end else if (o_cmd.load_sample && i_status.left_zero) begin
                        n_state = ST_DONE;
                    end
                end
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_accept || o_cmd.load_reject || o_cmd.load_sample) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ----- rtl/wav_pcm16_stream_to_dac.sv -----
// Results: a sample or rejected-header result is valid the cycle after its byte beat.
// An accepted-header result follows header byte 43 once the period divider is done and the
// result register is free: the divider resolves one quotient bit per cycle, or saturates
// on start when half the byte rate is zero; input stalls meanwhile.
// Throughput: one byte per cycle otherwise, limited by the single result register.
// Reset: synchronous, active low; parser idles until a start beat, pclk_hz = 25 MHz.
// ----------------------------------------------------------------------------
// wav_pcm16_stream_to_dac
// WAV PCM16 header parser and sample to 10-bit DAC code converter.
// ----------------------------------------------------------------------------
module wav_pcm16_stream_to_dac (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [wpd_pkg::WORD_W-1:0] i_cfg_wdata,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  wpd_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output wpd_pkg::t_out              o_out
);
    import wpd_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    wpd_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_file_start (i_in.file_start),
        .i_out_ready  (i_out_ready),
        .i_status     (w_status),
        .o_cmd        (w_cmd),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid)
    );

    wpd_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (i_in),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out       (o_out)
    );

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for wav_pcm16_stream_to_dac: feeds WAV byte streams
// (directed header/data cases, then random files and noise) under random
// back-pressure and compares every output beat against a byte-level parser
// model kept in the bench.
// ----------------------------------------------------------------------------
module tb;
    import wpd_pkg::*;

    localparam int WATCHDOG   = 1000;
    localparam int SETTLE_CYC = 40;
    localparam int RAND_BEATS = 200;
    // 0x0000, 0x7FFF, 0x8000, 0xFFFF as little-endian byte pairs
    localparam logic [63:0] EXT_PAT = 64'hFFFF_8000_7FFF_0000;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_DATA,
        PH_DONE
    } t_parse_phase;

    typedef struct {
        logic [31:0] riff;
        logic [31:0] form;
        logic [31:0] brate;
        logic [31:0] dsize;
        logic [7:0]  fmt_sz;
        logic [7:0]  chans;
        logic [7:0]  sbits;
        int          hdr_len;
        int          data_len;
        bit          extreme;
        bit          typed;
        t_out        want;
    } t_wav_file;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [WORD_W-1:0] i_cfg_wdata;
    logic              i_in_valid;
    logic              o_in_ready;
    t_in               i_in;
    logic              o_out_valid;
    logic              i_out_ready;
    t_out              o_out;

    wav_pcm16_stream_to_dac dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // parser model state
    logic [31:0]  m_pclk;
    t_parse_phase m_phase;
    logic [5:0]   m_idx;
    logic [31:0]  m_riff;
    logic [31:0]  m_form;
    logic [7:0]   m_fmt_lo;
    logic [7:0]   m_chans;
    logic [31:0]  m_brate;
    logic [7:0]   m_sbits_lo;
    logic [31:0]  m_left;
    logic [7:0]   m_pend;
    logic         m_odd;
    logic         m_right;

    t_out wav_results_q[$];
    int   n_errors;
    int   n_beats;
    int   n_used;
    int   n_files;
    int   n_accept;
    int   n_reject;
    int   n_samples;
    int   n_pclk;
    int   idle_cyc;
    bit   calm;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic parse_wav_byte(input t_in it, output bit got, output t_out r);
        logic [7:0]  b;
        logic [31:0] half;
        logic [15:0] raw;
        b   = it.data_byte;
        got = 1'b0;
        r   = '0;
        if (it.file_start) begin
            m_idx      = '0;
            m_riff     = '0;
            m_form     = '0;
            m_fmt_lo   = '0;
            m_chans    = '0;
            m_brate    = '0;
            m_sbits_lo = '0;
            m_left     = '0;
            m_pend     = '0;
            m_odd      = 1'b0;
            m_right    = 1'b0;
            m_phase    = PH_HEADER;
        end
        if (m_phase == PH_HEADER || m_phase == PH_DATA) n_used++;
        case (m_phase)
            PH_HEADER: begin
                if (m_idx < 4) m_riff = {m_riff[23:0], b};
                else if (m_idx >= 8 && m_idx < 12) m_form = {m_form[23:0], b};
                else if (m_idx == 16) m_fmt_lo = b;
                else if (m_idx == 22) m_chans = b;
                else if (m_idx >= 28 && m_idx < 32) m_brate[8*m_idx[1:0] +: 8] = b;
                else if (m_idx == 34) m_sbits_lo = b;
                else if (m_idx >= 40) m_left[8*m_idx[1:0] +: 8] = b;
                if (m_idx != HDR_LAST_IDX) begin
                    m_idx = m_idx + 1'b1;
                end else begin
                    m_idx = '0;
                    got = 1'b1;
                    r.channel_count = m_chans;
                    if (m_riff != TAG_RIFF || m_form != TAG_WAVE ||
                        m_fmt_lo != FMT_SIZE_PCM || m_sbits_lo != SAMPLE_BITS ||
                        (m_chans != CHAN_MONO && m_chans != CHAN_STEREO)) begin
                        m_phase = PH_DONE;
                        r.kind  = KIND_REJECT;
                    end else begin
                        half = m_brate >> 1;
                        r.kind         = KIND_ACCEPT;
                        r.dac_code     = DAC_MID;
                        r.timer_period = (half == 0) ? 32'hFFFF_FFFF : m_pclk / half;
                        r.last_sample  = (m_left == 0);
                        m_phase = (m_left == 0) ? PH_DONE : PH_DATA;
                        m_right = 1'b0;
                        m_odd   = 1'b0;
                    end
                end
            end
            PH_DATA: begin
                m_left = m_left - 1;
                if (!m_odd && m_left != 0) begin
                    m_pend = b;
                    m_odd  = 1'b1;
                end else begin
                    // a lone final byte is a low byte with a zero high byte
                    raw = m_odd ? {b, m_pend} : {8'h00, b};
                    got = 1'b1;
                    r.kind          = KIND_SAMPLE;
                    r.channel       = m_right;
                    r.dac_code      = {~raw[15], raw[14:6]};
                    r.channel_count = m_chans;
                    r.last_sample   = (m_left == 0);
                    m_right = (m_chans == CHAN_STEREO) ? ~m_right : 1'b0;
                    m_odd   = 1'b0;
                    if (m_left == 0) m_phase = PH_DONE;
                end
            end
            default: ;
        endcase
    endtask

    function automatic t_wav_file mk(input logic [31:0] riff, input logic [31:0] form,
                                     input logic [7:0] fmt_sz, input logic [7:0] chans,
                                     input logic [31:0] brate, input logic [7:0] sbits,
                                     input logic [31:0] dsize, input int hdr_len,
                                     input int data_len);
        t_wav_file f;
        f.riff     = riff;
        f.form     = form;
        f.fmt_sz   = fmt_sz;
        f.chans    = chans;
        f.brate    = brate;
        f.sbits    = sbits;
        f.dsize    = dsize;
        f.hdr_len  = hdr_len;
        f.data_len = data_len;
        f.extreme  = 1'b0;
        f.typed    = 1'b0;
        f.want     = '0;
        return f;
    endfunction

    function automatic t_out reject_beat(input logic [7:0] chans);
        t_out r;
        r = '0;
        r.kind          = KIND_REJECT;
        r.channel_count = chans;
        return r;
    endfunction

    function automatic t_out accept_beat(input logic [7:0] chans, input logic [31:0] period,
                                         input logic empty);
        t_out r;
        r = '0;
        r.kind          = KIND_ACCEPT;
        r.dac_code      = DAC_MID;
        r.timer_period  = period;
        r.channel_count = chans;
        r.last_sample   = empty;
        return r;
    endfunction

    function automatic logic [7:0] hdr_byte(input t_wav_file f, input int i);
        logic [7:0] v;
        v = 8'($urandom);
        case (i)
            0, 1, 2, 3:     v = f.riff[8*(3-i) +: 8];
            8, 9, 10, 11:   v = f.form[8*(11-i) +: 8];
            16:             v = f.fmt_sz;
            22:             v = f.chans;
            28, 29, 30, 31: v = f.brate[8*(i-28) +: 8];
            34:             v = f.sbits;
            40, 41, 42, 43: v = f.dsize[8*(i-40) +: 8];
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_beat(input t_in it, output bit got, output t_out r);
        if (!calm) begin
            while ($urandom_range(99) < 6) begin
                i_in_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        parse_wav_byte(it, got, r);
        n_beats++;
        calm = (n_used >= 350 && n_used < 550);
    endtask

    task automatic send_file(input t_wav_file f);
        t_in  it;
        bit   got;
        t_out r;
        int   k;
        for (k = 0; k < f.hdr_len + f.data_len; k++) begin
            it.file_start = (k == 0);
            if (k < f.hdr_len) it.data_byte = hdr_byte(f, k);
            else if (f.extreme) it.data_byte = EXT_PAT[8*((k - f.hdr_len) % 8) +: 8];
            else it.data_byte = 8'($urandom);
            send_beat(it, got, r);
            if (got) begin
                if (f.typed && k == HDR_LAST_IDX) r = f.want;
                wav_results_q.push_back(r);
            end
        end
        n_files++;
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (wav_results_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_pclk(input logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_pclk = v;
        n_pclk++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (got !== want) begin
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge i_clk) begin : rx_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (wav_results_q.size() == 0) begin
                $display("%0t ns: unexpected beat, expected none, actual %0h", $time, o_out);
                n_errors++;
            end else begin
                want = wav_results_q.pop_front();
                compare_field("kind", 32'(want.kind), 32'(o_out.kind));
                compare_field("channel", 32'(want.channel), 32'(o_out.channel));
                compare_field("dac_code", 32'(want.dac_code), 32'(o_out.dac_code));
                compare_field("timer_period", want.timer_period, o_out.timer_period);
                compare_field("channel_count", 32'(want.channel_count),
                              32'(o_out.channel_count));
                compare_field("last_sample", 32'(want.last_sample), 32'(o_out.last_sample));
            end
            case (o_out.kind)
                KIND_ACCEPT: n_accept++;
                KIND_REJECT: n_reject++;
                default:     n_samples++;
            endcase
        end
        i_out_ready <= calm || ($urandom_range(99) >= 6);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) idle_cyc <= 0;
        else idle_cyc <= idle_cyc + 1;
        if (idle_cyc >= WATCHDOG) begin
            $display("%0t ns: no beat for %0d cycles", $time, idle_cyc);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        t_wav_file   f;
        t_wav_file   dir_tab[$];
        logic [31:0] pclk_set[4];
        t_in         it;
        bit          got;
        t_out        r;
        int          ph;
        int          target;

        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_in        = '0;
        i_out_ready = 1'b0;
        n_errors = 0; n_beats = 0; n_used = 0; n_files = 0; n_pclk = 0;
        n_accept = 0; n_reject = 0; n_samples = 0; idle_cyc = 0; calm = 1'b0;
        m_pclk = PCLK_RESET; m_phase = PH_IDLE; m_idx = '0; m_riff = '0; m_form = '0;
        m_fmt_lo = '0; m_chans = '0; m_brate = '0; m_sbits_lo = '0; m_left = '0;
        m_pend = '0; m_odd = 1'b0; m_right = 1'b0;

        // directed files
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_MONO, 32'd50000, SAMPLE_BITS,
               32'd8, 44, 8);
        f.extreme = 1'b1; f.typed = 1'b1; f.want = accept_beat(CHAN_MONO, 32'd1000, 1'b0);
        dir_tab.push_back(f);
        // stereo, odd data size, trailing bytes after the data end
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_STEREO, 32'd176400, SAMPLE_BITS,
               32'd5, 44, 8);
        dir_tab.push_back(f);
        f = mk(32'h5249_4647, TAG_WAVE, FMT_SIZE_PCM, CHAN_MONO, 32'd8000, SAMPLE_BITS,
               32'd4, 44, 3);
        f.typed = 1'b1; f.want = reject_beat(CHAN_MONO);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, 32'h5741_5645 ^ 32'h8000_0000, FMT_SIZE_PCM, CHAN_STEREO,
               32'd8000, SAMPLE_BITS, 32'd4, 44, 2);
        f.typed = 1'b1; f.want = reject_beat(CHAN_STEREO);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, 8'd18, CHAN_MONO, 32'd8000, SAMPLE_BITS, 32'd4, 44, 0);
        f.typed = 1'b1; f.want = reject_beat(CHAN_MONO);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_MONO, 32'd8000, 8'd8, 32'd4, 44, 0);
        f.typed = 1'b1; f.want = reject_beat(CHAN_MONO);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, 8'd0, 32'd8000, SAMPLE_BITS, 32'd4, 44, 0);
        f.typed = 1'b1; f.want = reject_beat(8'd0);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, 8'd3, 32'd8000, SAMPLE_BITS, 32'd4, 44, 0);
        f.typed = 1'b1; f.want = reject_beat(8'd3);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, 8'hFF, 32'd8000, SAMPLE_BITS, 32'd4, 44, 0);
        f.typed = 1'b1; f.want = reject_beat(8'hFF);
        dir_tab.push_back(f);
        // half byte rate of zero saturates the period
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_STEREO, 32'd0, SAMPLE_BITS,
               32'd4, 44, 4);
        f.typed = 1'b1; f.want = accept_beat(CHAN_STEREO, 32'hFFFF_FFFF, 1'b0);
        dir_tab.push_back(f);
        // empty data chunk, bytes after it ignored
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_MONO, 32'd1, SAMPLE_BITS,
               32'd0, 44, 4);
        f.typed = 1'b1; f.want = accept_beat(CHAN_MONO, 32'hFFFF_FFFF, 1'b1);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_MONO, 32'd2, SAMPLE_BITS,
               32'd2, 44, 2);
        f.typed = 1'b1; f.want = accept_beat(CHAN_MONO, PCLK_RESET, 1'b0);
        dir_tab.push_back(f);
        // start during data, then start during header
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_MONO, 32'hFFFF_FFFF, SAMPLE_BITS,
               32'd40000, 44, 6);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_STEREO, 32'd96000, SAMPLE_BITS,
               32'd16, 20, 0);
        dir_tab.push_back(f);
        f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM, CHAN_STEREO, 32'd192000, SAMPLE_BITS,
               32'hFFFF_FFFF, 44, 10);
        f.extreme = 1'b1;
        dir_tab.push_back(f);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_pclk(PCLK_RESET);

        // bytes before any start are dropped
        repeat (3) begin
            it.data_byte = 8'($urandom);
            it.file_start = 1'b0;
            send_beat(it, got, r);
            if (got) wav_results_q.push_back(r);
        end
        foreach (dir_tab[i]) send_file(dir_tab[i]);

        pclk_set[0] = 32'd1;
        pclk_set[1] = 32'hFFFF_FFFF;
        pclk_set[2] = $urandom;
        pclk_set[3] = 32'd48000000;
        for (ph = 0; ph < 4; ph++) begin
            wait_idle();
            write_pclk(pclk_set[ph]);
            target = n_used + RAND_BEATS / 4;
            while (n_used < target) begin
                if ($urandom_range(99) < 8) begin
                    // noise burst, occasionally with a stray start
                    repeat ($urandom_range(1, 8)) begin
                        it.data_byte  = 8'($urandom);
                        it.file_start = ($urandom_range(15) == 0);
                        send_beat(it, got, r);
                        if (got) wav_results_q.push_back(r);
                    end
                end else begin
                    f = mk(TAG_RIFF, TAG_WAVE, FMT_SIZE_PCM,
                           $urandom_range(1) ? CHAN_STEREO : CHAN_MONO,
                           $urandom_range(2, 400000), SAMPLE_BITS,
                           $urandom_range(0, 24), 44, 0);
                    if ($urandom_range(99) < 4) f.riff = f.riff ^ (32'h1 << $urandom_range(31));
                    if ($urandom_range(99) < 4) f.form = f.form ^ (32'h1 << $urandom_range(31));
                    if ($urandom_range(99) < 4) f.fmt_sz = 8'($urandom);
                    if ($urandom_range(99) < 4) f.sbits = 8'($urandom);
                    if ($urandom_range(99) < 5) f.chans = 8'($urandom);
                    case ($urandom_range(9))
                        0:       f.brate = $urandom_range(1);
                        1, 2, 3: f.brate = $urandom;
                        default: ;
                    endcase
                    case ($urandom_range(9))
                        0:       f.dsize = $urandom;
                        1, 2:    f.dsize = $urandom_range(25, 120);
                        default: ;
                    endcase
                    f.data_len = (f.dsize > 60) ? $urandom_range(0, 60) : f.dsize;
                    if ($urandom_range(9) == 0) begin
                        f.data_len += $urandom_range(1, 6);
                    end else if ($urandom_range(9) == 0 && f.data_len > 0) begin
                        f.data_len = $urandom_range(0, f.data_len - 1);
                    end
                    if ($urandom_range(19) == 0) begin
                        f.hdr_len  = $urandom_range(1, 43);
                        f.data_len = 0;
                    end
                    f.extreme = ($urandom_range(9) == 0);
                    send_file(f);
                end
            end
        end

        wait_idle();
        $display("Ran %0d files over %0d input beats with %0d pclk settings.",
                 n_files, n_beats, n_pclk);
        $display("Output beats: %0d headers accepted, %0d rejected, %0d samples, %0d errors.",
                 n_accept, n_reject, n_samples, n_errors);
        if (n_errors == 0 && wav_results_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// ----- wav_pcm16_stream_to_dac.f -----
rtl/wpd_pkg.sv
rtl/wpd_div.sv
rtl/wpd_dp.sv
rtl/wpd_ctrl.sv
rtl/wav_pcm16_stream_to_dac.sv
bench/tb.sv
